/* hw/rtl/hall_sensor_histogram_median_top_macros.svh */
// Assertion helpers used by the top-level RTL.
`ifndef HALL_SENSOR_HISTOGRAM_MEDIAN_TOP_MACROS_SVH
`define HALL_SENSOR_HISTOGRAM_MEDIAN_TOP_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define HSHM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is low.
`define HSHM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/hshm_pkg.sv */
package hshm_pkg;

    localparam int SAMPLE_W = 12;
    localparam int PERIOD_W = 16;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [SAMPLE_W-1:0] MIN_FLOOR    = 12'd1000;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE   = 12'd4095;
    localparam logic [SAMPLE_W-1:0] GATE_RESET   = 12'd1850;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd300;

    // Register word index (paddr[2])
    localparam logic REG_GATE   = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BIN_RD,
        ST_BIN_WR,
        ST_SCAN,
        ST_CLOSE
    } t_state;

endpackage

/* hw/rtl/hshm_if.sv */
interface hshm_in_if;
    import hshm_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface hshm_out_if;
    import hshm_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] median_value;
    logic                median_found;
    logic                on_magnet;
    logic [SAMPLE_W-1:0] max_seen;
    logic [SAMPLE_W-1:0] min_seen;

    modport source (output valid, output median_value, output median_found,
                    output on_magnet, output max_seen, output min_seen, input ready);
    modport sink   (input valid, input median_value, input median_found,
                    input on_magnet, input max_seen, input min_seen, output ready);
endinterface

/* hw/rtl/hall_sensor_histogram_median_top.sv */
// Histogram median filter for one Hall sensor ADC channel.
// Input channel i_in carries one 12-bit sample and a last flag per item.
// Samples in [HIST_LOW, HIST_HIGH) bump a saturating bin in a single memory
// of HIST_HIGH-HIST_LOW entries; every sample bumps the window count.
// An out-of-range sample is taken in ST_IDLE alone; a binned one also passes
// through ST_BIN_RD and ST_BIN_WR (read, add, write back through the memory port).
// An item with last set then starts a scan over all NUM_BINS bins, in which
// one shared adder/comparator accumulates bins and each bin is zeroed behind
// the read; the close state follows. The scan over the memory sets the window
// throughput, and no new sample is taken until the block is back in idle.
// Output channel o_out holds one result per window in an output register;
// samples of the next window are taken while it waits. If the receiver
// stalls, the next window's close holds until the register is free.
// Reset: control state clears, registers go to gate 1850 / period 300, and
// a clearing pass over all NUM_BINS entries zeroes the memory; i_in.ready stays low
// during it, configuration writes are still taken.
// Config: APB port, gate_level at 0x0, reset_period at 0x4, pready always 1.
`include "hall_sensor_histogram_median_top_macros.svh"

module hall_sensor_histogram_median_top
    import hshm_pkg::*;
#(
    parameter int WINDOW_LEN = 64,
    parameter int HIST_LOW   = 1100,
    parameter int HIST_HIGH  = 2100
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    hshm_in_if.sink            i_in,
    hshm_out_if.source         o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);
    localparam int CW       = $clog2(WINDOW_LEN + 1);   // bin / window count
    localparam int AW       = CW + 1;                    // accumulator
    localparam int NUM_BINS = (HIST_HIGH > HIST_LOW) ? (HIST_HIGH - HIST_LOW) : 1;
    localparam int BIN_AW   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam logic [CW-1:0]       WIN_MAX  = CW'(WINDOW_LEN);
    localparam logic [SAMPLE_W-1:0] LO       = SAMPLE_W'(HIST_LOW);
    localparam logic [SAMPLE_W-1:0] HI       = SAMPLE_W'(HIST_HIGH);
    localparam logic [BIN_AW:0]     PTR_END  = (BIN_AW + 1)'(NUM_BINS);
    localparam logic [BIN_AW:0]     PTR_LAST = (BIN_AW + 1)'(NUM_BINS - 1);

    t_state r_state, n_state;

    logic [BIN_AW:0]       r_ptr;
    logic                  r_rd_pend;
    logic [BIN_AW-1:0]     r_scan_k;
    logic [BIN_AW-1:0]     r_idx;
    logic                  r_last;
    logic [CW-1:0]         r_wcnt;
    logic [AW-1:0]         r_acc;
    logic                  r_found;
    logic [SAMPLE_W-1:0]   r_median;
    logic [SAMPLE_W-1:0]   r_max;
    logic [SAMPLE_W-1:0]   r_min;
    logic [PERIOD_W-1:0]   r_wnum;
    logic [SAMPLE_W-1:0]   r_gate;
    logic [PERIOD_W-1:0]   r_period;
    logic                  r_out_valid;
    logic [SAMPLE_W-1:0]   r_out_median;
    logic                  r_out_found;
    logic                  r_out_magnet;
    logic [SAMPLE_W-1:0]   r_out_max;
    logic [SAMPLE_W-1:0]   r_out_min;

    logic                  accept;
    logic                  in_range;
    logic [SAMPLE_W-1:0]   offset;
    logic                  slot_free;
    logic                  scan_done;

    logic                  ram_we;
    logic [BIN_AW-1:0]     ram_waddr;
    logic [CW-1:0]         ram_wdata;
    logic                  ram_re;
    logic [BIN_AW-1:0]     ram_raddr;
    logic [CW-1:0]         ram_rdata;

    logic [AW-1:0]         alu_a, alu_b, alu_c, alu_sum;
    logic                  alu_gt;

    logic [PERIOD_W-1:0]   wnum_inc;
    logic                  period_hit;
    logic [SAMPLE_W-1:0]   max_base, min_base;
    logic [SAMPLE_W-1:0]   n_max, n_min;
    logic                  cfg_wr;

    hshm_ram #(.WIDTH(CW), .DEPTH(NUM_BINS), .AW(BIN_AW)) u_bins (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    hshm_alu #(.W(AW)) u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_c   (alu_c),
        .o_sum (alu_sum),
        .o_gt  (alu_gt)
    );

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign in_range   = (i_in.sample >= LO) && (i_in.sample < HI);
    assign offset     = i_in.sample - LO;
    assign slot_free  = !r_out_valid || o_out.ready;
    assign scan_done  = (r_ptr == PTR_END) && r_rd_pend;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_ptr == PTR_LAST) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    if (in_range)         n_state = ST_BIN_RD;
                    else if (i_in.last)   n_state = ST_SCAN;
                end
            end
            ST_BIN_RD: n_state = ST_BIN_WR;
            ST_BIN_WR: n_state = r_last ? ST_SCAN : ST_IDLE;
            ST_SCAN: begin
                if (scan_done) n_state = ST_CLOSE;
            end
            ST_CLOSE: begin
                if (slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Memory port and shared unit control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_idx;
        alu_a     = r_acc;
        alu_b     = {1'b0, ram_rdata};
        alu_c     = {1'b0, r_wcnt >> 1};
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr[BIN_AW-1:0];
            end
            ST_BIN_RD: begin
                ram_re = 1'b1;
            end
            ST_BIN_WR: begin
                // saturating increment of the bin
                alu_a     = {1'b0, ram_rdata};
                alu_b     = AW'(1);
                alu_c     = {1'b0, WIN_MAX};
                ram_we    = 1'b1;
                ram_wdata = alu_gt ? WIN_MAX : alu_sum[CW-1:0];
            end
            ST_SCAN: begin
                ram_re    = (r_ptr != PTR_END);
                ram_raddr = r_ptr[BIN_AW-1:0];
                // zero each bin once its count is in hand
                ram_we    = r_rd_pend;
                ram_waddr = r_scan_k;
            end
            ST_IDLE, ST_CLOSE: begin
                ram_we = 1'b0;
            end
            default: ram_we = 1'b0;
        endcase
    end

    // Window close: period clearing, then max has priority over min
    always_comb begin
        wnum_inc   = r_wnum + 1'b1;
        period_hit = (wnum_inc == r_period);
        max_base   = period_hit ? '0 : r_max;
        min_base   = period_hit ? FULL_SCALE : r_min;
        n_max      = max_base;
        n_min      = min_base;
        if (r_median > max_base) begin
            n_max = r_median;
        end else if ((r_median < min_base) && (r_median > MIN_FLOOR)) begin
            n_min = r_median;
        end
    end

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PERIOD) ? APB_DW'(r_period) : APB_DW'(r_gate);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_ptr       <= '0;
            r_rd_pend   <= 1'b0;
            r_wcnt      <= '0;
            r_acc       <= '0;
            r_found     <= 1'b0;
            r_median    <= '0;
            r_max       <= '0;
            r_min       <= FULL_SCALE;
            r_wnum      <= '0;
            r_gate      <= GATE_RESET;
            r_period    <= PERIOD_RESET;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state <= n_state;

            if (cfg_wr) begin
                if (paddr[2] == REG_GATE) r_gate <= pwdata[SAMPLE_W-1:0];
                else                      r_period <= pwdata[PERIOD_W-1:0];
            end

            if (r_state == ST_CLEAR) begin
                r_ptr <= r_ptr + 1'b1;
            end

            if (accept) begin
                r_idx  <= offset[BIN_AW-1:0];
                r_last <= i_in.last;
                if (r_wcnt < WIN_MAX) r_wcnt <= r_wcnt + 1'b1;
            end

            // Arm the scan
            if ((n_state == ST_SCAN) && (r_state != ST_SCAN)) begin
                r_ptr     <= '0;
                r_rd_pend <= 1'b0;
                r_acc     <= '0;
                r_found   <= 1'b0;
            end

            if (r_state == ST_SCAN) begin
                if (r_ptr != PTR_END) begin
                    r_scan_k  <= r_ptr[BIN_AW-1:0];
                    r_ptr     <= r_ptr + 1'b1;
                    r_rd_pend <= 1'b1;
                end else begin
                    r_rd_pend <= 1'b0;
                end
                // stop adding once the median is found
                if (r_rd_pend && !r_found) begin
                    r_acc <= alu_sum;
                    if (alu_gt) begin
                        r_found  <= 1'b1;
                        r_median <= LO + SAMPLE_W'(r_scan_k);
                    end
                end
            end

            // Load the result when the register frees up; drop it once taken.
            if ((r_state == ST_CLOSE) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if ((r_state == ST_CLOSE) && slot_free) begin
                r_wnum       <= period_hit ? '0 : wnum_inc;
                r_max        <= n_max;
                r_min        <= n_min;
                r_wcnt       <= '0;
                r_out_median <= r_median;
                r_out_found  <= r_found;
                r_out_magnet <= (r_median <= r_gate);
                r_out_max    <= n_max;
                r_out_min    <= n_min;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.median_value = r_out_median;
    assign o_out.median_found = r_out_found;
    assign o_out.on_magnet    = r_out_magnet;
    assign o_out.max_seen     = r_out_max;
    assign o_out.min_seen     = r_out_min;

    `HSHM_ASSERT_NOW(a_wcnt_cap, i_clk, i_rst_n, 1'b1, r_wcnt <= WIN_MAX, "window count over cap")
    `HSHM_ASSERT_NEXT(a_close_loads, i_clk, i_rst_n, (r_state == ST_CLOSE) && slot_free, o_out.valid && (r_state == ST_IDLE), "close did not load result")
    `HSHM_ASSERT_NOW(a_found_range, i_clk, i_rst_n, o_out.valid && o_out.median_found, (o_out.median_value >= LO) && (o_out.median_value < HI), "median outside histogram range")
    `HSHM_ASSERT_NOW(a_max_bound, i_clk, i_rst_n, o_out.valid, o_out.max_seen >= o_out.median_value, "running max below median")

endmodule

/* hw/rtl/hshm_ram.sv */
module hshm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hw/rtl/hshm_alu.sv */
// Shared add-and-compare: sum = a + b, gt = sum > c.
module hshm_alu #(
    parameter int W = 8
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_c,
    output logic [W-1:0] o_sum,
    output logic         o_gt
);
    always_comb begin
        o_sum = i_a + i_b;
        o_gt  = (o_sum > i_c);
    end
endmodule

/* sim/tb_hall_sensor_histogram_median_top.sv */
`timescale 1ns / 100ps

module tb_hall_sensor_histogram_median_top;
    import hshm_pkg::*;

    // Block configuration under test; the predictor uses the same values.
    localparam int WINDOW_LEN = 64;
    localparam int HIST_LOW   = 1100;
    localparam int HIST_HIGH  = 2100;
    localparam int NUM_BINS   = HIST_HIGH - HIST_LOW;
    localparam int TALLY_W    = $clog2(WINDOW_LEN + 1);

    // A result follows the scan over all NUM_BINS bins after its last item; wait well past that.
    localparam int DRAIN_CYCLES = NUM_BINS + 100;
    localparam int LONG_HOLD    = 4000;
    localparam int CYCLE_LIMIT  = 6000000;

    localparam logic [APB_AW-1:0] ADDR_GATE   = {REG_GATE, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_PERIOD = {REG_PERIOD, 2'b00};

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } sample_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] median_value;
        logic                median_found;
        logic                on_magnet;
        logic [SAMPLE_W-1:0] max_seen;
        logic [SAMPLE_W-1:0] min_seen;
    } median_result_t;

    // Shape of one random window.
    typedef enum int {
        WIN_CLUSTER,    // most samples near one value
        WIN_SPREAD,     // full-scale noise
        WIN_OUTSIDE,    // mostly outside the histogram range
        WIN_STUCK       // one value repeated, can drive its bin into saturation
    } window_style_t;

    logic i_clk;
    logic i_rst_n;

    hshm_in_if  in_ch();
    hshm_out_if out_ch();

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    hall_sensor_histogram_median_top #(
        .WINDOW_LEN (WINDOW_LEN),
        .HIST_LOW   (HIST_LOW),
        .HIST_HIGH  (HIST_HIGH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Items waiting to be offered, and results the predictor expects, oldest first.
    sample_item_t   queued_samples[$];
    median_result_t expected_medians[$];

    // Predictor state: histogram, window fill, medians, and the register copies.
    logic [TALLY_W-1:0]  bin_tally [NUM_BINS];
    logic [TALLY_W-1:0]  window_fill;
    logic [SAMPLE_W-1:0] median_now;
    logic [SAMPLE_W-1:0] max_now;
    logic [SAMPLE_W-1:0] min_now;
    logic [PERIOD_W-1:0] window_idx;
    logic [SAMPLE_W-1:0] gate_cfg;
    logic [PERIOD_W-1:0] period_cfg;

    // Pacing: percent of cycles in which each side idles.
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    logic        long_hold_req;

    int unsigned mismatch_count;
    int unsigned cycle_count;

    always #2 i_clk = ~i_clk;

    // Advance the histogram by one accepted item; on the last item of a window,
    // scan the bins, update the running max/min and queue the expected result.
    task automatic advance_histogram(input sample_item_t item);
        int unsigned    half;
        int unsigned    running;
        int             b;
        logic           hit;
        median_result_t res;
        // Every sample counts toward the window, in range or not; both saturate.
        if (window_fill < WINDOW_LEN) window_fill = window_fill + 1'b1;
        if (item.sample >= HIST_LOW && item.sample < HIST_HIGH) begin
            b = int'(item.sample) - HIST_LOW;
            if (bin_tally[b] < WINDOW_LEN) bin_tally[b] = bin_tally[b] + 1'b1;
        end
        if (!item.last) return;

        // First bin whose running total passes half the window wins; else keep old median.
        half    = window_fill >> 1;
        running = 0;
        hit     = 1'b0;
        for (b = 0; b < NUM_BINS && !hit; b++) begin
            running += bin_tally[b];
            if (running > half) begin
                median_now = SAMPLE_W'(HIST_LOW + b);
                hit        = 1'b1;
            end
        end

        // Clear max/min when the window counter meets the period; max has priority.
        window_idx = window_idx + 1'b1;
        if (window_idx == period_cfg) begin
            window_idx = '0;
            max_now    = '0;
            min_now    = FULL_SCALE;
        end
        if (median_now > max_now) begin
            max_now = median_now;
        end else if (median_now < min_now && median_now > MIN_FLOOR) begin
            min_now = median_now;
        end

        res.median_value = median_now;
        res.median_found = hit;
        res.on_magnet    = (median_now <= gate_cfg);
        res.max_seen     = max_now;
        res.min_seen     = min_now;
        expected_medians.push_back(res);

        for (b = 0; b < NUM_BINS; b++) bin_tally[b] = '0;
        window_fill = '0;
    endtask

    task automatic check_field(input string field_name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field_name, want, got);
            mismatch_count++;
        end
    endtask

    // Sender: hold the offered item until taken, then idle at random or offer the next.
    always @(posedge i_clk) begin : sample_driver
        sample_item_t taken;
        logic         offer;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            offer = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                taken = queued_samples.pop_front();
                advance_histogram(taken);
                offer = 1'b0;
            end
            if (!offer && queued_samples.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                offer        = 1'b1;
                in_ch.sample <= queued_samples[0].sample;
                in_ch.last   <= queued_samples[0].last;
            end
            in_ch.valid <= offer;
        end
    end

    // Receiver: check each taken result against the oldest expectation, then pick
    // ready for the next cycle. One long hold-off backs the block up into its input.
    always @(posedge i_clk) begin : result_monitor
        median_result_t want;
        int unsigned    hold_left;
        logic           long_hold_done;
        if (!i_rst_n) begin
            out_ch.ready   <= 1'b0;
            hold_left      = 0;
            long_hold_done = 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_medians.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual median %0d found %0b",
                             $time, out_ch.median_value, out_ch.median_found);
                    mismatch_count++;
                end else begin
                    want = expected_medians.pop_front();
                    check_field("median_value", want.median_value, out_ch.median_value);
                    check_field("median_found", want.median_found, out_ch.median_found);
                    check_field("on_magnet", want.on_magnet, out_ch.on_magnet);
                    check_field("max_seen", want.max_seen, out_ch.max_seen);
                    check_field("min_seen", want.min_seen, out_ch.min_seen);
                end
            end
            if (long_hold_req && !long_hold_done) begin
                hold_left      = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: end the run if it stalls.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // APB write: setup cycle, access cycle, done on the edge with pready high.
    task automatic write_register(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_gate(input logic [SAMPLE_W-1:0] value);
        write_register(ADDR_GATE, APB_DW'(value));
        gate_cfg = value;
    endtask

    task automatic set_period(input logic [PERIOD_W-1:0] value);
        write_register(ADDR_PERIOD, APB_DW'(value));
        period_cfg = value;
    endtask

    task automatic queue_item(input int sample, input logic last);
        sample_item_t item;
        item.sample = SAMPLE_W'(sample);
        item.last   = last;
        queued_samples.push_back(item);
    endtask

    // Wait until every item is taken and every result is in, then let the scan settle.
    task automatic wait_quiet();
        while (queued_samples.size() != 0 || expected_medians.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // The window counter only clears when it meets the period exactly, so bring it
    // back to zero with a period one past its current count before setting a small one.
    task automatic restart_period(input logic [PERIOD_W-1:0] target);
        set_period(PERIOD_W'(window_idx + 1'b1));
        queue_item(HIST_LOW, 1'b1);
        wait_quiet();
        set_period(target);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input window_style_t style,
                                                       input int center);
        int v;
        int r;
        r = int'($urandom_range(99));
        case (style)
            WIN_CLUSTER: begin
                if (r < 70) begin
                    v = center + int'($urandom_range(80)) - 40;
                end else if (r < 85) begin
                    v = int'($urandom_range(FULL_SCALE));
                end else begin
                    case ($urandom_range(5))
                        0:       v = 0;
                        1:       v = FULL_SCALE;
                        2:       v = HIST_LOW - 1;
                        3:       v = HIST_LOW;
                        4:       v = HIST_HIGH - 1;
                        default: v = HIST_HIGH;
                    endcase
                end
            end
            WIN_SPREAD: begin
                v = int'($urandom_range(FULL_SCALE));
            end
            WIN_OUTSIDE: begin
                if (r < 80) begin
                    v = r[0] ? int'($urandom_range(HIST_LOW - 1, 0))
                             : int'($urandom_range(FULL_SCALE, HIST_HIGH));
                end else begin
                    v = int'($urandom_range(HIST_HIGH - 1, HIST_LOW));
                end
            end
            default: begin
                v = (r < 95) ? center : int'($urandom_range(HIST_HIGH - 1, HIST_LOW));
            end
        endcase
        if (v < 0) v = 0;
        if (v > FULL_SCALE) v = FULL_SCALE;
        return SAMPLE_W'(v);
    endfunction

    // Queue whole windows until about item_goal items are queued. Most windows are
    // short so the scan does not dominate; a few run to 60-90 items, mostly past WINDOW_LEN, to saturate.
    task automatic queue_random_windows(input int unsigned item_goal);
        int unsigned   queued;
        int unsigned   len;
        int unsigned   pick;
        int unsigned   k;
        int            center;
        window_style_t style;
        queued = 0;
        while (queued < item_goal) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                len = $urandom_range(12, 1);
            end else if (pick < 95) begin
                len = $urandom_range(40, 13);
            end else begin
                len = $urandom_range(90, 60);
            end
            style = window_style_t'($urandom_range(3));
            if (len >= 60 && $urandom_range(1) == 1) style = WIN_STUCK;
            center = int'($urandom_range(HIST_HIGH + 59, HIST_LOW - 60));
            for (k = 0; k < len; k++) begin
                queue_item(pick_sample(style, center), k == len - 1);
            end
            queued += len;
        end
    endtask

    initial begin
        int b;
        // Drive every input to a known value from time zero.
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.sample   = '0;
        in_ch.last     = 1'b0;
        out_ch.ready   = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        long_hold_req  = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        tx_idle_pct    = 12;
        rx_idle_pct    = 78;

        // Predictor starts from the reset state.
        for (b = 0; b < NUM_BINS; b++) bin_tally[b] = '0;
        window_fill = '0;
        median_now  = '0;
        max_now     = '0;
        min_now     = FULL_SCALE;
        window_idx  = '0;
        gate_cfg    = GATE_RESET;
        period_cfg  = PERIOD_RESET;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed windows at the reset configuration.
        queue_item(0, 1'b1);                 // lowest sample, nothing binned, median kept at 0
        queue_item(FULL_SCALE, 1'b1);        // highest sample, out of range
        queue_item(HIST_LOW, 1'b1);          // lowest bin becomes the median
        queue_item(HIST_HIGH - 1, 1'b1);     // highest bin, new maximum
        queue_item(HIST_HIGH, 1'b0);         // just above and below the range still count
        queue_item(HIST_LOW - 1, 1'b0);
        queue_item(1500, 1'b1);              // so one binned sample of three finds nothing
        queue_item(1200, 1'b0);
        queue_item(1300, 1'b0);
        queue_item(1400, 1'b0);
        queue_item(1500, 1'b1);              // median 1400, new minimum above the floor
        queue_item(1300, 1'b0);
        queue_item(1300, 1'b0);
        queue_item(1900, 1'b1);              // two in one bin pass half of three
        queue_item(12'hAAA, 1'b0);           // alternating bit patterns
        queue_item(12'h555, 1'b1);
        wait_quiet();

        // Gate at zero, max/min cleared every window.
        set_gate('0);
        restart_period(16'd1);
        queue_random_windows(200);
        wait_quiet();

        // Gate at full scale, period of three windows; receiver now the fast side.
        tx_idle_pct <= 78;
        rx_idle_pct <= 12;
        set_gate(FULL_SCALE);
        restart_period(16'd3);
        queue_random_windows(200);
        wait_quiet();

        // Longest nonzero period; the receiver holds off while items keep coming.
        set_gate(12'd1500);
        set_period(16'hFFFF);
        long_hold_req <= 1'b1;
        queue_random_windows(220);
        wait_quiet();

        // Period zero acts as the full 16-bit count; no idling from here on.
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        set_gate(SAMPLE_W'($urandom_range(HIST_HIGH, HIST_LOW)));
        set_period('0);
        queue_random_windows(200);
        wait_quiet();

        set_gate(GATE_RESET);
        restart_period(16'd2);
        queue_random_windows(200);
        wait_quiet();

        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
